>>> sv/rcs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_pkg
// Shared widths for the rectangle clip and scale block.
// ---------------------------------------------------------------------------
package rcs_pkg;
  localparam int SIZE_BITS = 14;
  // Product d*B is below 2^28; doubled plus S fits in 30 bits.
  localparam int NUM_BITS = 2 * SIZE_BITS + 2;
  localparam int DEN_BITS = SIZE_BITS + 1;
  // Quotient never exceeds B, so SIZE_BITS + 1 bits are enough.
  localparam int QUO_BITS = SIZE_BITS + 1;
endpackage
`default_nettype wire

>>> sv/rcs_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_div
// Pipelined restoring divider: one quotient bit per stage, QUO_BITS stages.
// The quotient is known to fit in QUO_BITS bits, so the search starts there.
// ---------------------------------------------------------------------------
module rcs_div (
  input  wire logic                          clk,
  input  wire logic [rcs_pkg::NUM_BITS-1:0]  num,
  input  wire logic [rcs_pkg::DEN_BITS-1:0]  den,
  output logic      [rcs_pkg::QUO_BITS-1:0]  quo
);
  localparam int NB = rcs_pkg::NUM_BITS;
  localparam int DB = rcs_pkg::DEN_BITS;
  localparam int QB = rcs_pkg::QUO_BITS;
  localparam int RB = DB + 1;

  // Stage k holds the partial remainder, the numerator bits still to shift
  // in and the quotient bits found so far.
  logic [RB-1:0] rem  [QB+1];
  logic [NB-1:0] low  [QB+1];
  logic [DB-1:0] dvs  [QB+1];
  logic [QB-1:0] qacc [QB+1];

  // Entry: upper NB-QB numerator bits are already a remainder below den.
  always_comb begin
    rem[0]  = RB'(num[NB-1:QB]);
    low[0]  = num;
    dvs[0]  = den;
    qacc[0] = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RB-1:0] trial;
    logic          fits;
    always_comb begin
      trial = {rem[k][RB-2:0], low[k][QB-1-k]};
      fits  = trial >= RB'(dvs[k]);
    end
    always_ff @(posedge clk) begin
      rem[k+1]  <= fits ? trial - RB'(dvs[k]) : trial;
      low[k+1]  <= low[k];
      dvs[k+1]  <= dvs[k];
      qacc[k+1] <= {qacc[k][QB-2:0], fits};
    end
  end

  assign quo = qacc[QB];
endmodule
`default_nettype wire

>>> sv/rect_clip_and_scale_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rect_clip_and_scale_core
// Clips a logical rectangle to an output, scales it into the output's pixel
// buffer with round-half-up, and clips it to the buffer.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle; busy is never raised.
// Four pipelined restoring dividers, one per corner coordinate, set depth.
// Reset (rst, synchronous) clears the valid bits only; data is not reset.
// The receiver cannot stall, so done is a one-cycle strobe.
module rect_clip_and_scale_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_BITS-1:0] area_left,
  input  wire logic signed [COORD_BITS-1:0] area_top,
  input  wire logic [rcs_pkg::SIZE_BITS-1:0] area_wide,
  input  wire logic [rcs_pkg::SIZE_BITS-1:0] area_tall,
  input  wire logic signed [COORD_BITS-1:0] screen_left,
  input  wire logic signed [COORD_BITS-1:0] screen_top,
  input  wire logic [rcs_pkg::SIZE_BITS-1:0] screen_wide,
  input  wire logic [rcs_pkg::SIZE_BITS-1:0] screen_tall,
  input  wire logic [rcs_pkg::SIZE_BITS-1:0] buffer_wide,
  input  wire logic [rcs_pkg::SIZE_BITS-1:0] buffer_tall,
  output logic                           done,
  output logic [rcs_pkg::SIZE_BITS-1:0]  pixel_left,
  output logic [rcs_pkg::SIZE_BITS-1:0]  pixel_top,
  output logic [rcs_pkg::SIZE_BITS-1:0]  pixel_wide,
  output logic [rcs_pkg::SIZE_BITS-1:0]  pixel_tall,
  output logic                           is_empty
);
  localparam int SB = rcs_pkg::SIZE_BITS;
  localparam int NB = rcs_pkg::NUM_BITS;
  localparam int DB = rcs_pkg::DEN_BITS;
  localparam int QB = rcs_pkg::QUO_BITS;
  // The wider of a coordinate and a size, plus one bit for their sum and one
  // more for the difference of two such sums.
  localparam int EB = ((COORD_BITS > SB) ? COORD_BITS : SB) + 2;
  localparam int MB = 2 * SB;

  // The pipeline never stalls, so an item is taken every cycle.
  assign busy = 1'b0;

  // ---- Stage 1: corner sums and the empty-output test ----
  logic                 v1;
  logic signed [EB-1:0] ax0, ay0, ax1, ay1, sx0, sy0, sx1, sy1;
  logic [SB-1:0]        sw1, sh1, bw1, bh1;
  logic                 scr_empty1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    ax0 <= EB'(area_left);
    ay0 <= EB'(area_top);
    ax1 <= EB'(area_left) + EB'(signed'({1'b0, area_wide}));
    ay1 <= EB'(area_top) + EB'(signed'({1'b0, area_tall}));
    sx0 <= EB'(screen_left);
    sy0 <= EB'(screen_top);
    sx1 <= EB'(screen_left) + EB'(signed'({1'b0, screen_wide}));
    sy1 <= EB'(screen_top) + EB'(signed'({1'b0, screen_tall}));
    sw1 <= screen_wide;
    sh1 <= screen_tall;
    bw1 <= buffer_wide;
    bh1 <= buffer_tall;
    scr_empty1 <= (screen_wide == '0) || (screen_tall == '0);
  end

  // ---- Stage 2: intersection, offsets from the output origin ----
  logic                 v2;
  logic [SB-1:0]        dx0, dy0, dx1, dy1;
  logic [SB-1:0]        sw2, sh2, bw2, bh2;
  logic                 empty2;
  logic signed [EB-1:0] lx0, ly0, lx1, ly1;
  logic signed [EB-1:0] ox0, oy0, ox1, oy1;

  always_comb begin
    lx0 = (ax0 > sx0) ? ax0 : sx0;
    ly0 = (ay0 > sy0) ? ay0 : sy0;
    lx1 = (ax1 < sx1) ? ax1 : sx1;
    ly1 = (ay1 < sy1) ? ay1 : sy1;
    ox0 = lx0 - sx0;
    oy0 = ly0 - sy0;
    ox1 = lx1 - sx0;
    oy1 = ly1 - sy0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // Offsets lie within 0..S whenever the intersection is non-empty; an
  // empty item's offsets are don't-care and are masked at the end.
  always_ff @(posedge clk) begin
    dx0 <= ox0[SB-1:0];
    dy0 <= oy0[SB-1:0];
    dx1 <= ox1[SB-1:0];
    dy1 <= oy1[SB-1:0];
    sw2 <= sw1;
    sh2 <= sh1;
    bw2 <= bw1;
    bh2 <= bh1;
    empty2 <= scr_empty1 || (lx1 <= lx0) || (ly1 <= ly0);
  end

  // ---- Stage 3: products d*B ----
  logic          v3;
  logic [MB-1:0] mx0, my0, mx1, my1;
  logic [SB-1:0] sw3, sh3, bw3, bh3;
  logic          empty3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    mx0 <= MB'(dx0) * MB'(bw2);
    my0 <= MB'(dy0) * MB'(bh2);
    mx1 <= MB'(dx1) * MB'(bw2);
    my1 <= MB'(dy1) * MB'(bh2);
    sw3 <= sw2;
    sh3 <= sh2;
    bw3 <= bw2;
    bh3 <= bh2;
    empty3 <= empty2;
  end

  // ---- Division: floor((2*d*B + S) / (2*S)) ----
  logic [NB-1:0] nx0, ny0, nx1, ny1;
  logic [DB-1:0] ex, ey;
  logic [QB-1:0] qx0, qy0, qx1, qy1;

  always_comb begin
    nx0 = {1'b0, mx0, 1'b0} + NB'(sw3);
    ny0 = {1'b0, my0, 1'b0} + NB'(sh3);
    nx1 = {1'b0, mx1, 1'b0} + NB'(sw3);
    ny1 = {1'b0, my1, 1'b0} + NB'(sh3);
    ex  = {sw3, 1'b0};
    ey  = {sh3, 1'b0};
  end

  rcs_div u_div_x0 (.clk(clk), .num(nx0), .den(ex), .quo(qx0));
  rcs_div u_div_y0 (.clk(clk), .num(ny0), .den(ey), .quo(qy0));
  rcs_div u_div_x1 (.clk(clk), .num(nx1), .den(ex), .quo(qx1));
  rcs_div u_div_y1 (.clk(clk), .num(ny1), .den(ey), .quo(qy1));

  // Side data rides along the divider depth in a matching delay line.
  logic          vd    [QB+1];
  logic          ed    [QB+1];
  logic [SB-1:0] bwd   [QB+1];
  logic [SB-1:0] bhd   [QB+1];

  always_comb begin
    vd[0]  = v3;
    ed[0]  = empty3;
    bwd[0] = bw3;
    bhd[0] = bh3;
  end

  for (genvar k = 0; k < QB; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else begin
        vd[k+1] <= vd[k];
      end
    end
    always_ff @(posedge clk) begin
      ed[k+1]  <= ed[k];
      bwd[k+1] <= bwd[k];
      bhd[k+1] <= bhd[k];
    end
  end

  // ---- Final stage: clip to the buffer and form the result ----
  logic [QB-1:0] cx1, cy1;
  logic          fin_empty;

  always_comb begin
    cx1 = (qx1 < QB'(bwd[QB])) ? qx1 : QB'(bwd[QB]);
    cy1 = (qy1 < QB'(bhd[QB])) ? qy1 : QB'(bhd[QB]);
    fin_empty = ed[QB] || (cx1 <= qx0) || (cy1 <= qy0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[QB];
    end
  end

  always_ff @(posedge clk) begin
    is_empty   <= fin_empty;
    pixel_left <= fin_empty ? '0 : qx0[SB-1:0];
    pixel_top  <= fin_empty ? '0 : qy0[SB-1:0];
    pixel_wide <= fin_empty ? '0 : SB'(cx1 - qx0);
    pixel_tall <= fin_empty ? '0 : SB'(cy1 - qy0);
  end
endmodule
`default_nettype wire

>>> sv/rcs_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_checker
// Port-level checks for the rectangle clip and scale core.
// ---------------------------------------------------------------------------
module rcs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [rcs_pkg::SIZE_BITS-1:0] pixel_left,
  input wire logic [rcs_pkg::SIZE_BITS-1:0] pixel_top,
  input wire logic [rcs_pkg::SIZE_BITS-1:0] pixel_wide,
  input wire logic [rcs_pkg::SIZE_BITS-1:0] pixel_tall,
  input wire logic                          is_empty
);
  localparam int LAT = rcs_pkg::QUO_BITS + 4;

  // The core takes an item every cycle.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // An empty result is all zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (pixel_wide == '0 && pixel_tall == '0 &&
                            pixel_left == '0 && pixel_top == '0))
    else $error("empty result not zero");

  // A non-empty result has area.
  a_area: assert property (@(posedge clk) disable iff (rst)
    (done && !is_empty) |-> (pixel_wide != '0 && pixel_tall != '0))
    else $error("non-empty result has no area");

  // Each accepted item yields its result on done.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing");
endmodule

bind rect_clip_and_scale_core rcs_checker u_rcs_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .pixel_left(pixel_left), .pixel_top(pixel_top), .pixel_wide(pixel_wide),
  .pixel_tall(pixel_tall), .is_empty(is_empty)
);
`default_nettype wire
